// File: src/dual_alphabet_prefix_code_decoder_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-alphabet prefix-code decoder checker
// ----------------------------------------------------------------------------
`ifndef DUAL_ALPHABET_PREFIX_CODE_DECODER_TOP_ASSERT_SVH
`define DUAL_ALPHABET_PREFIX_CODE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define DAPCD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dapcd assertion failed");

// Next-cycle implication, disabled while reset is high
`define DAPCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dapcd assertion failed");

`endif

// File: src/dapcd_pkg.sv
// ----------------------------------------------------------------------------
// dapcd_pkg
// Shared types, code tables and classification for the prefix-code decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dapcd_pkg;

  localparam int WIN_W       = 15;
  localparam int CNT_W       = 4;
  localparam int IDX_W       = 6;
  localparam int STREET_SIZE = 56;
  localparam int PRON_SIZE   = 47;

  localparam logic [IDX_W-1:0] STREET_END = 6'd18;
  localparam logic [IDX_W-1:0] PRON_END   = 6'd16;
  localparam logic [CNT_W-1:0] END_LEN    = 4'd5;

  localparam logic [7:0] STREET_ROM [STREET_SIZE] = '{
    8'h00, 8'hD4, 8'h38, 8'h37, 8'h4D, 8'h52, 8'h53, 8'h45, 8'hCB, 8'hC6,
    8'h4F, 8'h20, 8'h49, 8'h47, 8'h4C, 8'h48, 8'h4E, 8'h54, 8'h0A, 8'h41,
    8'hCA, 8'hD8, 8'hC7, 8'hC2, 8'h2F, 8'h2C, 8'h29, 8'h28, 8'h39, 8'h30,
    8'h35, 8'h36, 8'h34, 8'h33, 8'h27, 8'h32, 8'h31, 8'h51, 8'h58, 8'h2E,
    8'h59, 8'h4A, 8'h56, 8'hC4, 8'hD6, 8'hDC, 8'h5A, 8'h50, 8'h46, 8'h2D,
    8'h4B, 8'h43, 8'h55, 8'h57, 8'h42, 8'h44
  };

  localparam logic [7:0] PRON_ROM [PRON_SIZE] = '{
    8'h00, 8'h76, 8'h6D, 8'h65, 8'h32, 8'h27, 8'h52, 8'h2E, 8'h26, 8'h53,
    8'h6C, 8'h6B, 8'h73, 8'h6E, 8'h5F, 8'h74, 8'h0A, 8'h61, 8'h3A, 8'h24,
    8'h41, 8'h5A, 8'h7E, 8'h25, 8'h6A, 8'h59, 8'h78, 8'h3F, 8'h2B, 8'h43,
    8'h79, 8'h4B, 8'h7A, 8'h55, 8'h75, 8'h70, 8'h6F, 8'h67, 8'h4F, 8'h64,
    8'h66, 8'h68, 8'h49, 8'h69, 8'h45, 8'h62, 8'h00
  };

  // Controller to datapath
  typedef struct packed {
    logic load;    // take the input byte into the bit window
    logic decode;  // decode one code into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;   // output register empty or being drained
    logic last_code;  // fewer than 8 bits remain after the current code
  } sts_t;

  typedef struct packed {
    logic [CNT_W-1:0] len;
    logic [IDX_W-1:0] idx;
  } cls_t;

  function automatic cls_t classify(input logic [7:0] v, input logic pron);
    cls_t c;
    c = '0;
    if (!pron) begin
      if (v inside {[8'd56:8'd111], [8'd4:8'd7]}) begin
        c.len = 4'd7; c.idx = IDX_W'(v >> 1);
      end else if (v >= 8'd160) begin
        c.len = 4'd3; c.idx = IDX_W'(v >> 5);
      end else if (v >= 8'd112) begin
        c.len = 4'd5; c.idx = IDX_W'(v >> 3);
      end else if (v inside {[8'd40:8'd55], [8'd16:8'd19]}) begin
        c.len = 4'd6; c.idx = IDX_W'(v >> 2);
      end else begin
        c.len = 4'd8; c.idx = IDX_W'(v);
      end
    end else begin
      if (v inside {[8'd56:8'd91]}) begin
        c.len = 4'd7; c.idx = IDX_W'(v >> 1);
      end else if (v >= 8'd160) begin
        c.len = 4'd3; c.idx = IDX_W'(v >> 5);
      end else if (v >= 8'd112) begin
        c.len = 4'd5; c.idx = IDX_W'(v >> 3);
      end else if (v inside {[8'd20:8'd27]}) begin
        c.len = 4'd8; c.idx = IDX_W'(v);
      end else begin
        c.len = 4'd6; c.idx = IDX_W'(v >> 2);
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] street_sym(input logic [IDX_W-1:0] idx);
    logic [7:0] s;
    s = 8'h00;
    if (idx < IDX_W'(STREET_SIZE)) s = STREET_ROM[idx];
    return s;
  endfunction

  function automatic logic [7:0] pron_sym(input logic [IDX_W-1:0] idx);
    logic [7:0] s;
    s = 8'h00;
    if (idx < IDX_W'(PRON_SIZE)) s = PRON_ROM[idx];
    return s;
  endfunction

endpackage

`default_nettype wire

// File: src/dapcd_ctrl.sv
// ----------------------------------------------------------------------------
// dapcd_ctrl
// Controller: accepts a byte, then steps decodes until the window runs low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dapcd_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dapcd_pkg::sts_t sts,
  output dapcd_pkg::cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DEC  = 1'b1;

  logic state;
  logic state_next;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.load   = in_ready && in_valid;
  assign cmd.decode = (state == ST_DEC) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_DEC;
      end
      ST_DEC: begin
        // return to idle once the final code of this byte is issued
        if (cmd.decode && sts.last_code) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: src/dapcd_dp.sv
// ----------------------------------------------------------------------------
// dapcd_dp
// Datapath: bit window, code classification, ROM lookup, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dapcd_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dapcd_pkg::cmd_t cmd,
  output dapcd_pkg::sts_t      sts,
  input  wire logic [7:0]      code_byte,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [7:0]           symbol,
  output logic                 section,
  output logic                 word_end,
  output logic                 last
);

  logic [dapcd_pkg::WIN_W-1:0] win;
  logic [dapcd_pkg::CNT_W-1:0] cnt;
  logic                        pron;

  logic [7:0]                  top_bits;
  dapcd_pkg::cls_t             cls;
  logic [dapcd_pkg::CNT_W-1:0] cnt_after;
  logic [dapcd_pkg::WIN_W-1:0] win_after;
  logic [dapcd_pkg::WIN_W-1:0] keep_mask;
  logic [6:0]                  load_mask;
  logic                        is_end;
  logic [7:0]                  sym;

  // while decoding cnt is 8..15, so the shift to the top byte is cnt - 8
  assign top_bits  = 8'(win >> cnt[2:0]);
  assign cls       = dapcd_pkg::classify(top_bits, pron);
  assign cnt_after = cnt - cls.len;
  assign keep_mask = (dapcd_pkg::WIN_W'(1) << cnt_after) - dapcd_pkg::WIN_W'(1);
  assign win_after = win & keep_mask;
  assign load_mask = (7'(1) << cnt[2:0]) - 7'(1);

  always_comb begin
    if (pron) begin
      is_end = (cls.len == dapcd_pkg::END_LEN) && (cls.idx == dapcd_pkg::PRON_END);
      sym    = dapcd_pkg::pron_sym(cls.idx);
    end else begin
      is_end = (cls.len == dapcd_pkg::END_LEN) && (cls.idx == dapcd_pkg::STREET_END);
      sym    = is_end ? 8'h00 : dapcd_pkg::street_sym(cls.idx);
    end
  end

  assign sts.out_free  = !out_valid || out_ready;
  assign sts.last_code = !cnt_after[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      win       <= '0;
      cnt       <= '0;
      pron      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        win <= {win[6:0] & load_mask, code_byte};
        cnt <= cnt + dapcd_pkg::CNT_W'(8);
      end else if (cmd.decode) begin
        win <= win_after;
        cnt <= cnt_after;
        if (is_end) pron <= !pron;
      end
      if (cmd.decode) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      symbol   <= sym;
      section  <= pron;
      word_end <= is_end;
      last     <= !cnt_after[3];
    end
  end

endmodule

`default_nettype wire

// File: src/dual_alphabet_prefix_code_decoder_top.sv
// A byte accepted on s_axis is loaded into the bit window; its codes then go to m_axis via the output register.
// Each byte has an accept step followed by one decode step per decoded code (1 to 3).
// The decode loop issues one code per cycle while the output register is free, through a single classify/ROM path.
// Output register lets the next byte be accepted while the final symbol waits.
// Reset (rst, synchronous, active high) empties the bit window and selects street.
// ----------------------------------------------------------------------------
// dual_alphabet_prefix_code_decoder_top
// Static prefix-code decoder with alternating street/pronunciation alphabets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dual_alphabet_prefix_code_decoder_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] code_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] symbol
  output logic [1:0]      m_axis_tuser,   // [0] section, [1] word_end
  output logic            m_axis_tlast
);

  dapcd_pkg::cmd_t cmd;
  dapcd_pkg::sts_t sts;
  logic            section;
  logic            word_end;

  dapcd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dapcd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .code_byte (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .symbol    (m_axis_tdata),
    .section   (section),
    .word_end  (word_end),
    .last      (m_axis_tlast)
  );

  assign m_axis_tuser = {word_end, section};

endmodule

`default_nettype wire

// File: src/dapcd_checker.sv
// ----------------------------------------------------------------------------
// dapcd_checker
// Port-level checks for the prefix-code decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dual_alphabet_prefix_code_decoder_top_assert.svh"

module dapcd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic [7:0] s_axis_tdata,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic [1:0] m_axis_tuser,
  input wire logic       m_axis_tlast
);

  logic        s_fire;
  logic        m_stall;
  logic [10:0] m_beat;
  logic        m_street_mark;
  logic        m_pron_mark;

  assign s_fire        = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata);
  assign m_stall       = m_axis_tvalid && !m_axis_tready;
  assign m_beat        = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign m_street_mark = m_axis_tvalid && m_axis_tuser[1] && !m_axis_tuser[0];
  assign m_pron_mark   = m_axis_tvalid && m_axis_tuser[1] && m_axis_tuser[0];

  // hold a stalled result
  `DAPCD_ASSERT_NEXT(a_hold_valid, clk, rst, m_stall, m_axis_tvalid)
  `DAPCD_ASSERT_NEXT(a_hold_data, clk, rst, m_stall, $stable(m_beat))
  // a byte in flight blocks the next one in the cycle after it is accepted
  `DAPCD_ASSERT_NEXT(a_one_byte, clk, rst, s_fire, !s_axis_tready)
  // street end marker carries no character
  `DAPCD_ASSERT_NOW(a_street_end, clk, rst, m_street_mark, m_axis_tdata == 8'h00)
  // pronunciation end marker carries a newline
  `DAPCD_ASSERT_NOW(a_pron_end, clk, rst, m_pron_mark, m_axis_tdata == 8'h0A)

endmodule

bind dual_alphabet_prefix_code_decoder_top dapcd_checker u_dapcd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
